// ===== rtl/core/dsa_pkg.sv =====
`default_nettype none

package dsa_pkg;

    localparam int SLOT_W    = 10;
    localparam int KIND_W    = 3;
    localparam int STRIDE_W  = 16;
    localparam int OFFSET_W  = 26;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int WIDX_W    = 5;
    localparam int SIZE_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam int VIEW_SLOTS_DEF    = 1024;
    localparam int SAMPLER_SLOTS_DEF = 16;
    localparam int TARGET_SLOTS_DEF  = 32;
    localparam int DEPTH_SLOTS_DEF   = 32;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_VIEW    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TARGET  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEPTH   = 3'd3;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_STRIDE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLER_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_STRIDE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_STRIDE   = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_FREE,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic latch;
        logic rd_next;
        logic scan_adv;
        logic alloc_wr;
        logic free_wr;
        logic mul;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic req_legal;
        logic req_free;
        logic found;
        logic last;
        logic out_free;
    } t_dp_sts;

    function automatic int map_words(int slots);
        map_words = (slots + WORD_W - 1) / WORD_W;
    endfunction

    function automatic logic [WORD_W-1:0] last_mask(int slots);
        int rem;
        rem = slots % WORD_W;
        last_mask = '1;
        if (rem != 0) begin
            last_mask = WORD_W'((33'd1 << rem) - 33'd1);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dsa_if.sv =====
`default_nettype none

interface dsa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [dsa_pkg::KIND_W-1:0]  pool_kind;
    logic [dsa_pkg::SLOT_W-1:0]  slot_index;
    logic                        handle_nonnull;

    modport source (output valid, command, pool_kind, slot_index, handle_nonnull,
                    input ready);
    modport sink   (input valid, command, pool_kind, slot_index, handle_nonnull,
                    output ready);
endinterface

interface dsa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [dsa_pkg::SLOT_W-1:0]   granted_index;
    logic [dsa_pkg::OFFSET_W-1:0] byte_offset;
    logic                         shader_visible;

    modport source (output valid, ok, granted_index, byte_offset, shader_visible,
                    input ready);
    modport sink   (input valid, ok, granted_index, byte_offset, shader_visible,
                    output ready);
endinterface

interface dsa_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dsa_pkg::CFG_IDX_W-1:0] index;
    logic [dsa_pkg::STRIDE_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/descriptor_slot_allocator.sv =====
// Descriptor slot allocator: four occupancy bitmaps (view, sampler, render
// target, depth target) held as 32-bit words in one map RAM.
// Request channel i_req: allocate takes the lowest free slot of pool_kind and
// answers with the slot index, index times the pool stride, and the
// shader-visible flag; free clears slot_index of pool_kind.
// Response channel o_rsp: exactly one response per request, in order.
// Config channel i_cfg: always ready; index 0..3 writes the view, sampler,
// render target or depth stride (reset 32). Write only while idle.
// Allocate scans the pool's map words in order until a free bit, one word
// a cycle through the map RAM read port; a full view pool scans all 32 words.
// One request is worked on at a time; the next is accepted in the cycle
// after the previous response is loaded.
// Reset: the map RAM is cleared one word a cycle, all 35 words with the
// default pool sizes, before the first request is accepted.
// Stall: the response holds in the output register until o_rsp.ready.
`default_nettype none

module descriptor_slot_allocator #(
    parameter int VIEW_SLOTS    = dsa_pkg::VIEW_SLOTS_DEF,
    parameter int SAMPLER_SLOTS = dsa_pkg::SAMPLER_SLOTS_DEF,
    parameter int TARGET_SLOTS  = dsa_pkg::TARGET_SLOTS_DEF,
    parameter int DEPTH_SLOTS   = dsa_pkg::DEPTH_SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dsa_req_if.sink   i_req,
    dsa_rsp_if.source o_rsp,
    dsa_cfg_if.sink   i_cfg
);

    dsa_pkg::t_dp_cmd cmd;
    dsa_pkg::t_dp_sts sts;
    logic             req_ready;

    assign i_req.ready = req_ready;

    dsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dsa_dp #(
        .VIEW_SLOTS    (VIEW_SLOTS),
        .SAMPLER_SLOTS (SAMPLER_SLOTS),
        .TARGET_SLOTS  (TARGET_SLOTS),
        .DEPTH_SLOTS   (DEPTH_SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dsa_ram.sv =====
`default_nettype none

module dsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/dsa_ctrl.sv =====
`default_nettype none

module dsa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire dsa_pkg::t_dp_sts  i_sts,
    output dsa_pkg::t_dp_cmd       o_cmd
);

    dsa_pkg::t_state r_state;
    dsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            dsa_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = dsa_pkg::ST_IDLE;
                end
            end
            dsa_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = i_sts.req_legal ? dsa_pkg::ST_FETCH : dsa_pkg::ST_DONE;
                end
            end
            dsa_pkg::ST_FETCH: begin
                n_state = i_sts.req_free ? dsa_pkg::ST_FREE : dsa_pkg::ST_SCAN;
            end
            dsa_pkg::ST_SCAN: begin
                o_cmd.rd_next = 1'b1;
                priority if (i_sts.found) begin
                    o_cmd.alloc_wr = 1'b1;
                    n_state = dsa_pkg::ST_MUL;
                end else if (i_sts.last) begin
                    n_state = dsa_pkg::ST_DONE;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                end
            end
            dsa_pkg::ST_FREE: begin
                o_cmd.free_wr = 1'b1;
                n_state = dsa_pkg::ST_DONE;
            end
            dsa_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = dsa_pkg::ST_DONE;
            end
            dsa_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = dsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dsa_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/dsa_dp.sv =====
`default_nettype none

module dsa_dp #(
    parameter int VIEW_SLOTS    = dsa_pkg::VIEW_SLOTS_DEF,
    parameter int SAMPLER_SLOTS = dsa_pkg::SAMPLER_SLOTS_DEF,
    parameter int TARGET_SLOTS  = dsa_pkg::TARGET_SLOTS_DEF,
    parameter int DEPTH_SLOTS   = dsa_pkg::DEPTH_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    dsa_req_if.sink                i_req,
    dsa_rsp_if.source              o_rsp,
    dsa_cfg_if.sink                i_cfg,
    input  wire dsa_pkg::t_dp_cmd  i_cmd,
    output dsa_pkg::t_dp_sts       o_sts
);

    localparam int WV    = dsa_pkg::map_words(VIEW_SLOTS);
    localparam int WS    = dsa_pkg::map_words(SAMPLER_SLOTS);
    localparam int WT    = dsa_pkg::map_words(TARGET_SLOTS);
    localparam int WD    = dsa_pkg::map_words(DEPTH_SLOTS);
    localparam int TOTAL = WV + WS + WT + WD;
    localparam int AW    = $clog2(TOTAL);

    localparam logic [AW-1:0] BASE_V = AW'(0);
    localparam logic [AW-1:0] BASE_S = AW'(WV);
    localparam logic [AW-1:0] BASE_T = AW'(WV + WS);
    localparam logic [AW-1:0] BASE_D = AW'(WV + WS + WT);

    localparam logic [dsa_pkg::WIDX_W-1:0] LAST_V = dsa_pkg::WIDX_W'(WV - 1);
    localparam logic [dsa_pkg::WIDX_W-1:0] LAST_S = dsa_pkg::WIDX_W'(WS - 1);
    localparam logic [dsa_pkg::WIDX_W-1:0] LAST_T = dsa_pkg::WIDX_W'(WT - 1);
    localparam logic [dsa_pkg::WIDX_W-1:0] LAST_D = dsa_pkg::WIDX_W'(WD - 1);

    localparam logic [dsa_pkg::WORD_W-1:0] MASK_V = dsa_pkg::last_mask(VIEW_SLOTS);
    localparam logic [dsa_pkg::WORD_W-1:0] MASK_S = dsa_pkg::last_mask(SAMPLER_SLOTS);
    localparam logic [dsa_pkg::WORD_W-1:0] MASK_T = dsa_pkg::last_mask(TARGET_SLOTS);
    localparam logic [dsa_pkg::WORD_W-1:0] MASK_D = dsa_pkg::last_mask(DEPTH_SLOTS);

    localparam logic [dsa_pkg::SIZE_W-1:0] SIZE_V = dsa_pkg::SIZE_W'(VIEW_SLOTS);
    localparam logic [dsa_pkg::SIZE_W-1:0] SIZE_S = dsa_pkg::SIZE_W'(SAMPLER_SLOTS);
    localparam logic [dsa_pkg::SIZE_W-1:0] SIZE_T = dsa_pkg::SIZE_W'(TARGET_SLOTS);
    localparam logic [dsa_pkg::SIZE_W-1:0] SIZE_D = dsa_pkg::SIZE_W'(DEPTH_SLOTS);

    logic [dsa_pkg::STRIDE_W-1:0] r_stride_v;
    logic [dsa_pkg::STRIDE_W-1:0] r_stride_s;
    logic [dsa_pkg::STRIDE_W-1:0] r_stride_t;
    logic [dsa_pkg::STRIDE_W-1:0] r_stride_d;

    logic [AW-1:0]                r_clr;
    logic                         r_command;
    logic [1:0]                   r_kind;
    logic [dsa_pkg::BIT_W-1:0]    r_bit;
    logic [dsa_pkg::WIDX_W-1:0]   r_word;
    logic                         r_ok;
    logic [dsa_pkg::SLOT_W-1:0]   r_index;
    logic [dsa_pkg::OFFSET_W-1:0] r_offset;
    logic                         r_sv;

    logic                         r_out_valid;
    logic                         r_out_ok;
    logic [dsa_pkg::SLOT_W-1:0]   r_out_index;
    logic [dsa_pkg::OFFSET_W-1:0] r_out_offset;
    logic                         r_out_sv;

    logic [AW-1:0]                base;
    logic [dsa_pkg::WIDX_W-1:0]   last_word;
    logic [dsa_pkg::WORD_W-1:0]   tail_mask;
    logic [dsa_pkg::STRIDE_W-1:0] stride;
    logic [dsa_pkg::SIZE_W-1:0]   in_size;
    logic                         last;
    logic [dsa_pkg::WIDX_W-1:0]   rd_word;
    logic [AW-1:0]                rd_addr;
    logic [AW-1:0]                word_addr;
    logic [dsa_pkg::WORD_W-1:0]   rd_data;
    logic [dsa_pkg::WORD_W-1:0]   free_bits;
    logic                         found;
    logic [dsa_pkg::BIT_W-1:0]    found_bit;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [dsa_pkg::WORD_W-1:0]   wr_data;
    logic [dsa_pkg::OFFSET_W-1:0] product;
    logic                         in_kind_ok;

    always_comb begin
        unique case (r_kind)
            2'd0: begin
                base = BASE_V; last_word = LAST_V; tail_mask = MASK_V; stride = r_stride_v;
            end
            2'd1: begin
                base = BASE_S; last_word = LAST_S; tail_mask = MASK_S; stride = r_stride_s;
            end
            2'd2: begin
                base = BASE_T; last_word = LAST_T; tail_mask = MASK_T; stride = r_stride_t;
            end
            default: begin
                base = BASE_D; last_word = LAST_D; tail_mask = MASK_D; stride = r_stride_d;
            end
        endcase
    end

    always_comb begin
        in_kind_ok = 1'b1;
        unique case (i_req.pool_kind)
            dsa_pkg::KIND_VIEW:    in_size = SIZE_V;
            dsa_pkg::KIND_SAMPLER: in_size = SIZE_S;
            dsa_pkg::KIND_TARGET:  in_size = SIZE_T;
            dsa_pkg::KIND_DEPTH:   in_size = SIZE_D;
            default: begin
                in_size    = '0;
                in_kind_ok = 1'b0;
            end
        endcase
    end

    assign last      = (r_word == last_word);
    assign rd_word   = (i_cmd.rd_next && !last) ? r_word + 1'b1 : r_word;
    assign rd_addr   = base + AW'(rd_word);
    assign word_addr = base + AW'(r_word);
    assign free_bits = ~rd_data & (last ? tail_mask : '1);

    always_comb begin
        found     = 1'b0;
        found_bit = '0;
        for (int b = dsa_pkg::WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                found     = 1'b1;
                found_bit = dsa_pkg::BIT_W'(b);
            end
        end
    end

    always_comb begin
        wr_en   = i_cmd.clr_wr | i_cmd.alloc_wr | i_cmd.free_wr;
        wr_addr = word_addr;
        wr_data = rd_data;
        priority if (i_cmd.clr_wr) begin
            wr_addr = r_clr;
            wr_data = '0;
        end else if (i_cmd.alloc_wr) begin
            wr_data = rd_data | (dsa_pkg::WORD_W'(1) << found_bit);
        end else begin
            wr_data = rd_data & ~(dsa_pkg::WORD_W'(1) << r_bit);
        end
    end

    dsa_ram #(
        .WIDTH (dsa_pkg::WORD_W),
        .DEPTH (TOTAL)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign product = dsa_pkg::OFFSET_W'(r_index) * dsa_pkg::OFFSET_W'(stride);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride_v <= dsa_pkg::STRIDE_RESET;
            r_stride_s <= dsa_pkg::STRIDE_RESET;
            r_stride_t <= dsa_pkg::STRIDE_RESET;
            r_stride_d <= dsa_pkg::STRIDE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dsa_pkg::REG_VIEW_STRIDE:    r_stride_v <= i_cfg.data;
                dsa_pkg::REG_SAMPLER_STRIDE: r_stride_s <= i_cfg.data;
                dsa_pkg::REG_TARGET_STRIDE:  r_stride_t <= i_cfg.data;
                default:                     r_stride_d <= i_cfg.data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_command <= i_req.command;
            r_kind    <= i_req.pool_kind[1:0];
            r_bit     <= i_req.slot_index[dsa_pkg::BIT_W-1:0];
            r_word    <= (i_req.command == dsa_pkg::CMD_FREE)
                         ? i_req.slot_index[dsa_pkg::SLOT_W-1:dsa_pkg::BIT_W] : '0;
            r_ok      <= 1'b0;
            r_index   <= '0;
            r_offset  <= '0;
            r_sv      <= 1'b0;
        end else begin
            if (i_cmd.scan_adv) begin
                r_word <= r_word + 1'b1;
            end
            if (i_cmd.alloc_wr) begin
                r_ok    <= 1'b1;
                r_index <= {r_word, found_bit};
                r_sv    <= ~r_kind[1];
            end
            if (i_cmd.free_wr) begin
                r_ok <= 1'b1;
            end
            if (i_cmd.mul) begin
                r_offset <= product;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_ok     <= r_ok;
            r_out_index  <= r_index;
            r_out_offset <= r_offset;
            r_out_sv     <= r_sv;
        end
    end

    assign i_cfg.ready          = 1'b1;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.ok             = r_out_ok;
    assign o_rsp.granted_index  = r_out_index;
    assign o_rsp.byte_offset    = r_out_offset;
    assign o_rsp.shader_visible = r_out_sv;

    assign o_sts.clr_last  = (r_clr == AW'(TOTAL - 1));
    assign o_sts.req_legal = in_kind_ok && ((i_req.command == dsa_pkg::CMD_ALLOC)
                             || (i_req.handle_nonnull
                                 && ({1'b0, i_req.slot_index} < in_size)));
    assign o_sts.req_free  = (r_command == dsa_pkg::CMD_FREE);
    assign o_sts.found     = found;
    assign o_sts.last      = last;
    assign o_sts.out_free  = !r_out_valid || o_rsp.ready;

endmodule

`default_nettype wire
